// ===== rtl/core/rabe_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rabe_pkg
// Opcodes, fault codes and sizes shared by the register ALU / branch unit.
// ----------------------------------------------------------------------------
package rabe_pkg;

  localparam int RegCount = 16;
  localparam int RegIdxW  = $clog2(RegCount);
  localparam int PcW      = 16;
  localparam int DataW    = 32;

  localparam logic [7:0] OP_MOV  = 8'h00;
  localparam logic [7:0] OP_SET  = 8'h01;
  localparam logic [7:0] OP_ADD  = 8'h10;
  localparam logic [7:0] OP_SUB  = 8'h11;
  localparam logic [7:0] OP_MUL  = 8'h12;
  localparam logic [7:0] OP_DIV  = 8'h13;
  localparam logic [7:0] OP_REM  = 8'h14;
  localparam logic [7:0] OP_OR   = 8'h15;
  localparam logic [7:0] OP_AND  = 8'h16;
  localparam logic [7:0] OP_XOR  = 8'h17;
  localparam logic [7:0] OP_NOT  = 8'h18;
  localparam logic [7:0] OP_SHL  = 8'h19;
  localparam logic [7:0] OP_SHR  = 8'h1A;
  localparam logic [7:0] OP_CMP  = 8'h20;
  localparam logic [7:0] OP_JZ   = 8'h21;
  localparam logic [7:0] OP_JNZ  = 8'h22;
  localparam logic [7:0] OP_JC   = 8'h23;
  localparam logic [7:0] OP_JNC  = 8'h24;
  localparam logic [7:0] OP_JBE  = 8'h25;
  localparam logic [7:0] OP_JA   = 8'h26;
  localparam logic [7:0] OP_JMP  = 8'h40;
  localparam logic [7:0] OP_JMPR = 8'h41;

  localparam logic [1:0] FAULT_NONE   = 2'd0;
  localparam logic [1:0] FAULT_DIV0   = 2'd1;
  localparam logic [1:0] FAULT_UNSUPP = 2'd2;

endpackage
`default_nettype wire

// ===== rtl/core/register_alu_branch_execute_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// register_alu_branch_execute_unit
// Executes one decoded instruction per transfer against a 16 x 32 register
// memory and Z/C flags; returns written value, next pc, flags and fault.
// ----------------------------------------------------------------------------
// channel  dir  tdata fields (low bit first)                             tuser
// s_axis   in   func[7:0] dst[11:8] src[15:12] imm[47:16] pc[63:48]      -
// m_axis   out  result[31:0] wrote[32] next_pc[48:33] z[49] c[50]
//               fault[52:51], zero fill to 56 bits                        -
// After reset a sweep clears the register memory; no input is taken meanwhile.
// Per item: idle to idle through accept, two memory reads, execute, output;
// mul adds multiply states and div/rem the divider (one quotient bit per cycle).
// Input is taken only in idle; a result waits in the output register under
// back-pressure, the next item can be accepted alongside it and then holds
// in the output state until the register frees.
// ----------------------------------------------------------------------------
module register_alu_branch_execute_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [63:0] s_axis_tdata,   // func, dst_index, src_index, immediate, current_pc
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [55:0]      m_axis_tdata    // result_value, wrote_register, next_pc,
                                           // zero_flag, carry_flag, fault
);

  localparam int AW = rabe_pkg::RegIdxW;
  localparam int DW = rabe_pkg::DataW;
  localparam int PW = rabe_pkg::PcW;

  typedef enum logic [7:0] {
    S_CLEAR = 8'b0000_0001,
    S_IDLE  = 8'b0000_0010,
    S_RDA   = 8'b0000_0100,
    S_RDB   = 8'b0000_1000,
    S_EXEC  = 8'b0001_0000,
    S_MUL   = 8'b0010_0000,
    S_DIV   = 8'b0100_0000,
    S_OUT   = 8'b1000_0000
  } state_t;

  state_t state;

  logic [DW-1:0] regmem [rabe_pkg::RegCount];
  logic [DW-1:0] rd_data;
  logic [AW-1:0] rd_addr;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [DW-1:0] wr_data;

  logic [7:0]    func;
  logic [AW-1:0] dst;
  logic [AW-1:0] src;
  logic [DW-1:0] imm;
  logic [PW-1:0] pc;
  logic [DW-1:0] opa;
  logic [DW-1:0] opb;
  logic          zf;
  logic          cf;
  logic [AW:0]   clr_cnt;

  logic [DW-1:0] prod_ll;
  logic [DW-1:0] prod_lh;
  logic [DW-1:0] prod_hl;
  logic [1:0]    mul_step;

  logic [DW-1:0] quo;
  logic [DW-1:0] rem;
  logic [5:0]    div_cnt;
  logic [DW:0]   rem_shift;
  logic [DW:0]   rem_try;

  logic          out_valid;
  logic [DW-1:0] o_val;
  logic          o_wr;
  logic [PW-1:0] o_pc;
  logic          o_z;
  logic          o_c;
  logic [1:0]    o_fault;

  logic          hold_free;
  assign hold_free = !out_valid || m_axis_tready;

  assign s_axis_tready = (state == S_IDLE);
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {3'b000, o_fault, o_c, o_z, o_pc, o_wr, o_val};

  always_comb begin
    case (state)
      S_IDLE:  rd_addr = s_axis_tdata[8 +: AW];
      S_RDA:   rd_addr = src;
      default: rd_addr = dst;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      regmem[wr_addr] <= wr_data;
    end
    rd_data <= regmem[rd_addr];
  end

  assign rem_shift = {rem, quo[DW-1]};
  assign rem_try   = rem_shift - {1'b0, opb};

  // execute result
  logic [DW-1:0] ex_val;
  logic          ex_wr;
  logic          ex_take;
  logic [PW-1:0] ex_pc;
  logic [1:0]    ex_fault;
  logic          ex_setf;
  logic [PW-1:0] target;

  assign target = pc + imm[PW-1:0];

  always_comb begin
    ex_val   = '0;
    ex_wr    = 1'b0;
    ex_take  = 1'b0;
    ex_pc    = pc;
    ex_fault = rabe_pkg::FAULT_NONE;
    ex_setf  = 1'b0;
    case (func)
      rabe_pkg::OP_MOV:  begin ex_val = opb; ex_wr = 1'b1; end
      rabe_pkg::OP_SET:  begin ex_val = imm; ex_wr = 1'b1; end
      rabe_pkg::OP_ADD:  begin ex_val = opa + opb; ex_wr = 1'b1; end
      rabe_pkg::OP_SUB:  begin ex_val = opa - opb; ex_wr = 1'b1; end
      rabe_pkg::OP_MUL:  begin ex_val = prod_ll + ((prod_lh + prod_hl) << 16); ex_wr = 1'b1; end
      rabe_pkg::OP_DIV:  begin ex_val = quo; ex_wr = (opb != '0); end
      rabe_pkg::OP_REM:  begin ex_val = rem; ex_wr = (opb != '0); end
      rabe_pkg::OP_OR:   begin ex_val = opa | opb; ex_wr = 1'b1; end
      rabe_pkg::OP_AND:  begin ex_val = opa & opb; ex_wr = 1'b1; end
      rabe_pkg::OP_XOR:  begin ex_val = opa ^ opb; ex_wr = 1'b1; end
      rabe_pkg::OP_NOT:  begin ex_val = ~opa; ex_wr = 1'b1; end
      rabe_pkg::OP_SHL:  begin ex_val = opa << opb[4:0]; ex_wr = 1'b1; end
      rabe_pkg::OP_SHR:  begin ex_val = opa >> opb[4:0]; ex_wr = 1'b1; end
      rabe_pkg::OP_CMP:  ex_setf = 1'b1;
      rabe_pkg::OP_JZ:   ex_take = zf;
      rabe_pkg::OP_JNZ:  ex_take = !zf;
      rabe_pkg::OP_JC:   ex_take = cf;
      rabe_pkg::OP_JNC:  ex_take = !cf;
      rabe_pkg::OP_JBE:  ex_take = cf || zf;
      rabe_pkg::OP_JA:   ex_take = !cf && !zf;
      rabe_pkg::OP_JMP:  ex_take = 1'b1;
      rabe_pkg::OP_JMPR: ex_pc = opa[PW-1:0];
      default:           ex_fault = rabe_pkg::FAULT_UNSUPP;
    endcase
    if ((func == rabe_pkg::OP_DIV || func == rabe_pkg::OP_REM) && opb == '0) begin
      ex_fault = rabe_pkg::FAULT_DIV0;
      ex_val   = '0;
    end
    if (ex_take) begin
      ex_pc = target;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_cnt   <= '0;
      zf        <= 1'b0;
      cf        <= 1'b0;
      out_valid <= 1'b0;
      wr_en     <= 1'b0;
    end else begin
      wr_en <= (state == S_CLEAR && !clr_cnt[AW]) || (state == S_EXEC && ex_wr);
      if (state == S_OUT && hold_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && m_axis_tready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          wr_addr <= clr_cnt[AW-1:0];
          wr_data <= '0;
          clr_cnt <= clr_cnt + (AW+1)'(1);
          if (clr_cnt == (AW+1)'(rabe_pkg::RegCount)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (s_axis_tvalid) begin
            func  <= s_axis_tdata[7:0];
            dst   <= s_axis_tdata[8 +: AW];
            src   <= s_axis_tdata[12 +: AW];
            imm   <= s_axis_tdata[47:16];
            pc    <= s_axis_tdata[63:48];
            state <= S_RDA;
          end
        end
        S_RDA: begin
          opa   <= rd_data;
          state <= S_RDB;
        end
        S_RDB: begin
          if (func == rabe_pkg::OP_MUL) begin
            mul_step <= '0;
            state    <= S_MUL;
          end else if (func == rabe_pkg::OP_DIV || func == rabe_pkg::OP_REM) begin
            quo     <= opa;
            rem     <= '0;
            div_cnt <= '0;
            state   <= S_DIV;
          end else begin
            state <= S_EXEC;
          end
        end
        S_MUL: begin
          mul_step <= mul_step + 2'd1;
          prod_ll  <= DW'(opa[15:0] * opb[15:0]);
          prod_lh  <= DW'(opa[15:0] * opb[31:16]);
          prod_hl  <= DW'(opa[31:16] * opb[15:0]);
          if (mul_step == 2'd1) begin
            state <= S_EXEC;
          end
        end
        S_DIV: begin
          div_cnt <= div_cnt + 6'd1;
          if (rem_try[DW]) begin
            rem <= rem_shift[DW-1:0];
            quo <= {quo[DW-2:0], 1'b0};
          end else begin
            rem <= rem_try[DW-1:0];
            quo <= {quo[DW-2:0], 1'b1};
          end
          if (div_cnt == 6'(DW - 1)) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (ex_setf) begin
            zf <= (opa == opb);
            cf <= (opa < opb);
          end
          wr_addr <= dst;
          wr_data <= ex_val;
          state   <= S_OUT;
        end
        S_OUT: begin
          if (hold_free) begin
            o_val   <= ex_wr ? ex_val : '0;
            o_wr    <= ex_wr;
            o_pc    <= ex_pc;
            o_fault <= ex_fault;
            o_z     <= zf;
            o_c     <= cf;
            state   <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // second operand captured the cycle after its read address
  always_ff @(posedge clk) begin
    if (state == S_RDB) begin
      opb <= rd_data;
    end
  end

  // first read (dst) issued in the accepting idle cycle, second (src) in S_RDA

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !s_axis_tready)
    else $error("accept outside idle");

  a_div0_no_write: assert property (@(posedge clk) disable iff (rst)
    (state == S_EXEC && (func == rabe_pkg::OP_DIV || func == rabe_pkg::OP_REM)
     && opb == '0) |=> !wr_en)
    else $error("write on divide by zero");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !m_axis_tready) |=> out_valid && $stable(m_axis_tdata))
    else $error("result lost under stall");

endmodule
`default_nettype wire

// ===== tb/sv/rabe_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rabe_checker
// Watches both stream channels of the execute unit, keeps its own copy of
// the register file and flags, predicts each result and compares in order.
// ----------------------------------------------------------------------------
module rabe_checker (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  input  wire logic        s_axis_tready,
  input  wire logic [63:0] s_axis_tdata,
  input  wire logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  input  wire logic [55:0] m_axis_tdata,
  output int               fail_count,
  output int               pending_count
);

  typedef struct packed {
    logic [1:0]                 fault;
    logic                       c;
    logic                       z;
    logic [rabe_pkg::PcW-1:0]   next_pc;
    logic                       wrote;
    logic [rabe_pkg::DataW-1:0] value;
  } exec_result_t;

  logic [rabe_pkg::DataW-1:0] regs [rabe_pkg::RegCount];
  logic                       flag_z, flag_c;
  exec_result_t               expected_results [$];

  function automatic exec_result_t execute_instr(input logic [63:0] d);
    logic [7:0]                 op;
    logic [rabe_pkg::DataW-1:0] a, b, imm, val;
    logic [rabe_pkg::PcW-1:0]   pc, tgt, nxt;
    logic                       wr, take;
    logic [1:0]                 flt;
    exec_result_t               r;
    op   = d[7:0];
    a    = regs[d[11:8]];
    b    = regs[d[15:12]];
    imm  = d[47:16];
    pc   = d[63:48];
    tgt  = pc + imm[15:0];
    nxt  = pc;
    val  = '0;
    wr   = 1'b0;
    take = 1'b0;
    flt  = rabe_pkg::FAULT_NONE;
    case (op)
      rabe_pkg::OP_MOV: begin val = b; wr = 1; end
      rabe_pkg::OP_SET: begin val = imm; wr = 1; end
      rabe_pkg::OP_ADD: begin val = a + b; wr = 1; end
      rabe_pkg::OP_SUB: begin val = a - b; wr = 1; end
      rabe_pkg::OP_MUL: begin val = a * b; wr = 1; end
      rabe_pkg::OP_DIV, rabe_pkg::OP_REM: begin
        if (b == 0) flt = rabe_pkg::FAULT_DIV0;
        else begin
          val = (op == rabe_pkg::OP_DIV) ? a / b : a % b;
          wr = 1;
        end
      end
      rabe_pkg::OP_OR:  begin val = a | b; wr = 1; end
      rabe_pkg::OP_AND: begin val = a & b; wr = 1; end
      rabe_pkg::OP_XOR: begin val = a ^ b; wr = 1; end
      rabe_pkg::OP_NOT: begin val = ~a; wr = 1; end
      rabe_pkg::OP_SHL: begin val = a << b[4:0]; wr = 1; end
      rabe_pkg::OP_SHR: begin val = a >> b[4:0]; wr = 1; end
      rabe_pkg::OP_CMP: begin flag_z = (a == b); flag_c = (a < b); end
      rabe_pkg::OP_JZ:   take = flag_z;
      rabe_pkg::OP_JNZ:  take = !flag_z;
      rabe_pkg::OP_JC:   take = flag_c;
      rabe_pkg::OP_JNC:  take = !flag_c;
      rabe_pkg::OP_JBE:  take = flag_c || flag_z;
      rabe_pkg::OP_JA:   take = !flag_c && !flag_z;
      rabe_pkg::OP_JMP:  take = 1;
      rabe_pkg::OP_JMPR: nxt = a[rabe_pkg::PcW-1:0];
      default: flt = rabe_pkg::FAULT_UNSUPP;
    endcase
    if (take) nxt = tgt;
    if (wr) regs[d[11:8]] = val;
    r.value   = wr ? val : '0;
    r.wrote   = wr;
    r.next_pc = nxt;
    r.z       = flag_z;
    r.c       = flag_c;
    r.fault   = flt;
    return r;
  endfunction

  assign pending_count = expected_results.size();

  always @(posedge clk) begin
    exec_result_t exp_r, got;
    if (rst) begin
      foreach (regs[i]) regs[i] = '0;
      flag_z = 0;
      flag_c = 0;
      expected_results.delete();
      fail_count <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready)
        expected_results.insert(expected_results.size(), execute_instr(s_axis_tdata));
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata[52:0];
        if (expected_results.size() == 0) begin
          fail_count <= fail_count + 1;
          if (fail_count < 10) $display("unexpected result %h", got);
        end else begin
          exp_r = expected_results.pop_front();
          if (got !== exp_r || m_axis_tdata[55:53] !== 3'b0) begin
            fail_count <= fail_count + 1;
            if (fail_count < 10)
              $display("mismatch: exp val %h wr %b pc %h z %b c %b f %0d / got %h",
                       exp_r.value, exp_r.wrote, exp_r.next_pc, exp_r.z, exp_r.c,
                       exp_r.fault, m_axis_tdata);
          end
        end
      end
    end
  end

endmodule

// ===== tb/sv/register_alu_branch_execute_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// register_alu_branch_execute_unit_tb
// Directed and random instruction streams into the execute unit under
// varied idling and a long output stall; the checker scores every result.
// ----------------------------------------------------------------------------
module register_alu_branch_execute_unit_tb;

  localparam int CycleLimit = 400000;

  logic        clk = 0;
  logic        rst = 1;
  logic        s_axis_tvalid = 0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 0;
  logic [55:0] m_axis_tdata;
  int          fail_count, pending_count;
  int          send_idle_pct = 28, recv_idle_pct = 85;
  bit          hold_off = 0;
  int          cycle_count = 0;

  logic [7:0] op_list [22] = '{rabe_pkg::OP_MOV, rabe_pkg::OP_SET, rabe_pkg::OP_ADD,
    rabe_pkg::OP_SUB, rabe_pkg::OP_MUL, rabe_pkg::OP_DIV, rabe_pkg::OP_REM,
    rabe_pkg::OP_OR, rabe_pkg::OP_AND, rabe_pkg::OP_XOR, rabe_pkg::OP_NOT,
    rabe_pkg::OP_SHL, rabe_pkg::OP_SHR, rabe_pkg::OP_CMP, rabe_pkg::OP_JZ,
    rabe_pkg::OP_JNZ, rabe_pkg::OP_JC, rabe_pkg::OP_JNC, rabe_pkg::OP_JBE,
    rabe_pkg::OP_JA, rabe_pkg::OP_JMP, rabe_pkg::OP_JMPR};

  register_alu_branch_execute_unit u_top (.*);

  rabe_checker u_checker (.*);

  initial forever #2 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  always @(negedge clk)
    m_axis_tready <= !rst && !hold_off && ($urandom_range(99) >= recv_idle_pct);

  task automatic send_instr(input logic [7:0] op, input logic [3:0] rd,
                            input logic [3:0] rs, input logic [31:0] imm,
                            input logic [15:0] pc);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 0;
      @(negedge clk);
    end
    s_axis_tdata  <= {pc, imm, rs, rd, op};
    s_axis_tvalid <= 1;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(3))
      0: return $urandom_range(3);
      1: return 32'hffffffff - $urandom_range(3);
      2: return $urandom_range(40);
      default: return $urandom;
    endcase
  endfunction

  task automatic random_instr();
    logic [7:0] op;
    int k;
    k = $urandom_range(99);
    if (k < 30) op = rabe_pkg::OP_SET;
    else if (k < 95) op = op_list[5'($urandom_range(21))];
    else op = 8'($urandom);
    send_instr(op, 4'($urandom), 4'($urandom), rand_word(), 16'($urandom));
  endtask

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    // directed: extremes, every opcode, divide by zero, flags, unsupported codes
    send_instr(rabe_pkg::OP_DIV, 4'd1, 4'd2, 32'd0, 16'h0000);
    send_instr(rabe_pkg::OP_REM, 4'd1, 4'd2, 32'd0, 16'hffff);
    send_instr(rabe_pkg::OP_SET, 4'd1, 4'd0, 32'hffffffff, 16'h1234);
    send_instr(rabe_pkg::OP_SET, 4'd2, 4'd0, 32'h0000001f, 16'h1234);
    send_instr(rabe_pkg::OP_SET, 4'd15, 4'd0, 32'h80000001, 16'hffff);
    send_instr(rabe_pkg::OP_CMP, 4'd2, 4'd1, 32'd0, 16'd0);
    send_instr(rabe_pkg::OP_JC, 4'd0, 4'd0, 32'h0000ffff, 16'hffff);
    send_instr(rabe_pkg::OP_JA, 4'd0, 4'd0, 32'h0000ffff, 16'h0001);
    send_instr(rabe_pkg::OP_CMP, 4'd1, 4'd1, 32'd0, 16'd0);
    send_instr(rabe_pkg::OP_JBE, 4'd0, 4'd0, 32'hffff8000, 16'h9000);
    send_instr(rabe_pkg::OP_JNZ, 4'd0, 4'd0, 32'h10, 16'h10);
    foreach (op_list[i]) send_instr(op_list[i], i[3:0], 4'(15 - i), 32'hffff, 16'hfff0);
    send_instr(8'hff, 4'd3, 4'd4, 32'd0, 16'd0);
    send_instr(8'h02, 4'd3, 4'd4, 32'd0, 16'd0);
    for (int n = 0; n < 850; n++) begin
      if (n == 280) begin send_idle_pct = 85; recv_idle_pct = 28; end
      if (n == 560) begin send_idle_pct = 0; recv_idle_pct = 0; end
      random_instr();
    end
    s_axis_tvalid <= 0;
    while (pending_count != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (fail_count == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    wait (!rst);
    repeat (3000) @(posedge clk);
    hold_off = 1;
    repeat (400) @(posedge clk);
    hold_off = 0;
  end

endmodule
